// ===== rtl/iaas_pkg.sv =====
// ============================================================================
// iaas_pkg
// Types, constants, microprogram and helper functions shared by the
// admittance axis step unit.
// ============================================================================
package iaas_pkg;

    // field and register widths
    localparam int GAIN_W    = 10;
    localparam int GAIN_AXES = 6;
    localparam int PACK_W    = GAIN_W * GAIN_AXES;
    localparam int TS_W      = 16;
    localparam int LIM_W     = 15;
    localparam int AXIS_W    = 3;
    localparam int VAL_W     = 16;
    localparam int ACC_W     = 22;
    localparam int PROD_W    = 27;
    localparam int OPA_W     = 22;
    localparam int OPB_W     = 17;
    localparam int MUL_W     = OPA_W + OPB_W;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;

    // reset values of the configuration registers
    localparam logic [PACK_W-1:0] INV_MASS_RESET = 60'd72128031568756800;
    localparam logic [TS_W-1:0]   TS_RESET       = 16'd2621;
    localparam logic [LIM_W-1:0]  ACC_LIM_RESET  = 15'd64;
    localparam logic [LIM_W-1:0]  VEL_LIM_RESET  = 15'd77;

    // register indexes
    localparam logic [2:0] REG_DAMP  = 3'd0;
    localparam logic [2:0] REG_STIFF = 3'd1;
    localparam logic [2:0] REG_IMASS = 3'd2;
    localparam logic [2:0] REG_TSTEP = 3'd3;
    localparam logic [2:0] REG_ALIM  = 3'd4;
    localparam logic [2:0] REG_VLIM  = 3'd5;

    // microprogram size and entry points
    localparam int STEP_COUNT = 10;
    localparam int STEP_W     = 4;
    localparam logic [STEP_W-1:0] STEP_BAD_AXIS = 4'd9;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_SUB,
        ALU_ACLAMP,
        ALU_VEL,
        ALU_POS,
        ALU_ZERO
    } alu_op_t;

    typedef enum logic [1:0] {
        OPA_VEL,
        OPA_POS,
        OPA_ACC
    } opa_t;

    typedef enum logic [1:0] {
        OPB_DAMP,
        OPB_STIFF,
        OPB_IMASS,
        OPB_TSTEP
    } opb_t;

    typedef struct packed {
        logic              mul_en;
        opa_t              opa;
        opb_t              opb;
        logic              shift16;
        alu_op_t           alu;
        logic              jmp_bad;
        logic [STEP_W-1:0] target;
        logic              last;
        logic              wr_state;
    } ctrl_word_t;

    typedef struct packed {
        logic             load;
        logic             step_en;
        ctrl_word_t       word;
    } dp_ctrl_t;

    typedef struct packed {
        logic              bad_axis;
        logic [AXIS_W-1:0] axis;
        logic [VAL_W-1:0]  position;
    } dp_status_t;

    typedef struct packed {
        logic [PACK_W-1:0] damp;
        logic [PACK_W-1:0] stiff;
        logic [PACK_W-1:0] imass;
        logic [TS_W-1:0]   tstep;
        logic [LIM_W-1:0]  alim;
        logic [LIM_W-1:0]  vlim;
    } cfg_t;

    // control store: one word per step
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{mul_en: 1'b0, opa: OPA_VEL, opb: OPB_DAMP, shift16: 1'b0,
              alu: ALU_NOP, jmp_bad: 1'b0, target: '0, last: 1'b0, wr_state: 1'b0};
        case (step)
            4'd0:
            begin
                // damping product, leave at once for an axis out of range
                w.mul_en  = 1'b1;
                w.opa     = OPA_VEL;
                w.opb     = OPB_DAMP;
                w.jmp_bad = 1'b1;
                w.target  = STEP_BAD_AXIS;
            end
            4'd1:
            begin
                w.alu    = ALU_SUB;
                w.mul_en = 1'b1;
                w.opa    = OPA_POS;
                w.opb    = OPB_STIFF;
            end
            4'd2:
            begin
                w.alu = ALU_SUB;
            end
            4'd3:
            begin
                w.mul_en = 1'b1;
                w.opa    = OPA_ACC;
                w.opb    = OPB_IMASS;
            end
            4'd4:
            begin
                w.alu = ALU_ACLAMP;
            end
            4'd5:
            begin
                w.mul_en  = 1'b1;
                w.opa     = OPA_ACC;
                w.opb     = OPB_TSTEP;
                w.shift16 = 1'b1;
            end
            4'd6:
            begin
                w.alu = ALU_VEL;
            end
            4'd7:
            begin
                w.mul_en  = 1'b1;
                w.opa     = OPA_ACC;
                w.opb     = OPB_TSTEP;
                w.shift16 = 1'b1;
            end
            4'd8:
            begin
                w.alu      = ALU_POS;
                w.last     = 1'b1;
                w.wr_state = 1'b1;
            end
            4'd9:
            begin
                w.alu  = ALU_ZERO;
                w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    // one packed gain, zero beyond the packed axes
    function automatic logic [GAIN_W-1:0] gain_of(input logic [PACK_W-1:0] packed_gains,
                                                  input logic [AXIS_W-1:0] axis);
        logic [GAIN_W-1:0] g;
        g = '0;
        for (int i = 0; i < GAIN_AXES; i++)
        begin
            if (axis == AXIS_W'(i))
            begin
                g = packed_gains[i*GAIN_W +: GAIN_W];
            end
        end
        return g;
    endfunction

    // symmetric clamp to +/- lim
    function automatic logic signed [VAL_W-1:0] clamp_sym(input logic signed [PROD_W-1:0] value,
                                                          input logic [LIM_W-1:0] lim);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        logic signed [VAL_W-1:0]  r;
        hi = $signed({{(PROD_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (value > hi)
        begin
            r = hi[VAL_W-1:0];
        end
        else if (value < lo)
        begin
            r = lo[VAL_W-1:0];
        end
        else
        begin
            r = value[VAL_W-1:0];
        end
        return r;
    endfunction

    // saturate to the signed 16-bit range
    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [VAL_W+1:0] value);
        logic signed [VAL_W-1:0] r;
        if (value > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (value < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = value[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/iaas_if.sv =====
// ============================================================================
// iaas_if
// Valid/ready channels for force samples and position results.
// ============================================================================
interface iaas_sample_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               axis;
    logic signed [15:0]       force_req;

    modport source (output valid, output axis, output force_req, input ready);
    modport sink   (input valid, input axis, input force_req, output ready);
endinterface

interface iaas_result_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               axis_out;
    logic signed [15:0]       position;

    modport source (output valid, output axis_out, output position, input ready);
    modport sink   (input valid, input axis_out, input position, output ready);
endinterface

// ===== rtl/iaas_regs.sv =====
// ============================================================================
// iaas_regs
// APB-style configuration registers: gains, time step and limits.
// ============================================================================
module iaas_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iaas_pkg::ADDR_W-1:0]   paddr,
    input  logic [iaas_pkg::DATA_W-1:0]   pwdata,
    output logic [iaas_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output iaas_pkg::cfg_t                cfg
);

    iaas_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[5:3];
    assign cfg    = cfg_reg;

    // register writes, masked to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.damp  <= '0;
            cfg_reg.stiff <= '0;
            cfg_reg.imass <= iaas_pkg::INV_MASS_RESET;
            cfg_reg.tstep <= iaas_pkg::TS_RESET;
            cfg_reg.alim  <= iaas_pkg::ACC_LIM_RESET;
            cfg_reg.vlim  <= iaas_pkg::VEL_LIM_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                iaas_pkg::REG_DAMP:  cfg_reg.damp  <= pwdata[iaas_pkg::PACK_W-1:0];
                iaas_pkg::REG_STIFF: cfg_reg.stiff <= pwdata[iaas_pkg::PACK_W-1:0];
                iaas_pkg::REG_IMASS: cfg_reg.imass <= pwdata[iaas_pkg::PACK_W-1:0];
                iaas_pkg::REG_TSTEP: cfg_reg.tstep <= pwdata[iaas_pkg::TS_W-1:0];
                iaas_pkg::REG_ALIM:  cfg_reg.alim  <= pwdata[iaas_pkg::LIM_W-1:0];
                iaas_pkg::REG_VLIM:  cfg_reg.vlim  <= pwdata[iaas_pkg::LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (index)
            iaas_pkg::REG_DAMP:  prdata = iaas_pkg::DATA_W'(cfg_reg.damp);
            iaas_pkg::REG_STIFF: prdata = iaas_pkg::DATA_W'(cfg_reg.stiff);
            iaas_pkg::REG_IMASS: prdata = iaas_pkg::DATA_W'(cfg_reg.imass);
            iaas_pkg::REG_TSTEP: prdata = iaas_pkg::DATA_W'(cfg_reg.tstep);
            iaas_pkg::REG_ALIM:  prdata = iaas_pkg::DATA_W'(cfg_reg.alim);
            iaas_pkg::REG_VLIM:  prdata = iaas_pkg::DATA_W'(cfg_reg.vlim);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/iaas_datapath.sv =====
// ============================================================================
// iaas_datapath
// Shared multiplier, accumulator and per-axis velocity/position store,
// driven one control word per cycle by the sequencer unless a result stalls.
// ============================================================================
module iaas_datapath
#(
    parameter int AXIS_COUNT = 6
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  iaas_pkg::dp_ctrl_t                  ctrl,
    input  logic [iaas_pkg::AXIS_W-1:0]         axis_in,
    input  logic signed [iaas_pkg::VAL_W-1:0]   force_in,
    input  iaas_pkg::cfg_t                      cfg,
    output iaas_pkg::dp_status_t                status
);

    localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    logic signed [iaas_pkg::VAL_W-1:0]  vel_mem [AXIS_COUNT];
    logic signed [iaas_pkg::VAL_W-1:0]  pos_mem [AXIS_COUNT];

    logic [iaas_pkg::AXIS_W-1:0]        axis_reg;
    logic signed [iaas_pkg::VAL_W-1:0]  v_reg;
    logic signed [iaas_pkg::VAL_W-1:0]  x_reg;
    logic signed [iaas_pkg::ACC_W-1:0]  acc_reg;
    logic signed [iaas_pkg::ACC_W-1:0]  acc_next;
    logic signed [iaas_pkg::PROD_W-1:0] prod_reg;
    logic signed [iaas_pkg::PROD_W-1:0] prod_next;

    logic [IDX_W-1:0]                   in_idx;
    logic                               in_ok;
    logic [IDX_W-1:0]                   idx;
    logic                               bad_axis;

    logic signed [iaas_pkg::OPA_W-1:0]  opa_val;
    logic signed [iaas_pkg::OPB_W-1:0]  opb_val;
    logic signed [iaas_pkg::MUL_W-1:0]  product;
    logic signed [iaas_pkg::MUL_W-1:0]  shifted;
    logic signed [iaas_pkg::VAL_W+1:0]  sum_vel;
    logic signed [iaas_pkg::VAL_W+1:0]  sum_pos;
    logic signed [iaas_pkg::VAL_W-1:0]  clamp_val;
    logic                               wr_state;

    assign in_idx   = axis_in[IDX_W-1:0];
    assign in_ok    = int'(axis_in) < AXIS_COUNT;
    assign idx      = axis_reg[IDX_W-1:0];
    assign bad_axis = int'(axis_reg) >= AXIS_COUNT;
    assign wr_state = ctrl.step_en & ctrl.word.last & ctrl.word.wr_state & ~bad_axis;

    // multiplier operand selection
    always_comb
    begin
        case (ctrl.word.opa)
            iaas_pkg::OPA_VEL: opa_val = iaas_pkg::OPA_W'(v_reg);
            iaas_pkg::OPA_POS: opa_val = iaas_pkg::OPA_W'(x_reg);
            iaas_pkg::OPA_ACC: opa_val = acc_reg;
            default:           opa_val = '0;
        endcase
        case (ctrl.word.opb)
            iaas_pkg::OPB_DAMP:
                opb_val = $signed({7'd0, iaas_pkg::gain_of(cfg.damp, axis_reg)});
            iaas_pkg::OPB_STIFF:
                opb_val = $signed({7'd0, iaas_pkg::gain_of(cfg.stiff, axis_reg)});
            iaas_pkg::OPB_IMASS:
                opb_val = $signed({7'd0, iaas_pkg::gain_of(cfg.imass, axis_reg)});
            iaas_pkg::OPB_TSTEP:
                opb_val = $signed({1'b0, cfg.tstep});
            default:
                opb_val = '0;
        endcase
    end

    // product, floor-shifted by 6 for gains or 16 for the time step
    always_comb
    begin
        product   = opa_val * opb_val;
        shifted   = ctrl.word.shift16 ? (product >>> 16) : (product >>> 6);
        prod_next = shifted[iaas_pkg::PROD_W-1:0];
    end

    // accumulator operations
    always_comb
    begin
        sum_vel   = {{2{v_reg[iaas_pkg::VAL_W-1]}}, v_reg} + prod_reg[iaas_pkg::VAL_W+1:0];
        sum_pos   = {{2{x_reg[iaas_pkg::VAL_W-1]}}, x_reg} + prod_reg[iaas_pkg::VAL_W+1:0];
        clamp_val = '0;
        case (ctrl.word.alu)
            iaas_pkg::ALU_SUB:
                acc_next = acc_reg - prod_reg[iaas_pkg::ACC_W-1:0];
            iaas_pkg::ALU_ACLAMP:
            begin
                clamp_val = iaas_pkg::clamp_sym(prod_reg, cfg.alim);
                acc_next  = iaas_pkg::ACC_W'(clamp_val);
            end
            iaas_pkg::ALU_VEL:
            begin
                clamp_val = iaas_pkg::clamp_sym(iaas_pkg::PROD_W'(sum_vel), cfg.vlim);
                acc_next  = iaas_pkg::ACC_W'(clamp_val);
            end
            iaas_pkg::ALU_POS:
                acc_next = iaas_pkg::ACC_W'(iaas_pkg::sat16(sum_pos));
            iaas_pkg::ALU_ZERO:
                acc_next = '0;
            default:
                acc_next = acc_reg;
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            axis_reg <= axis_in;
            acc_reg  <= iaas_pkg::ACC_W'(force_in);
            v_reg    <= in_ok ? vel_mem[in_idx] : '0;
            x_reg    <= in_ok ? pos_mem[in_idx] : '0;
        end
        else if (ctrl.step_en)
        begin
            acc_reg <= acc_next;
            if (ctrl.word.mul_en)
            begin
                prod_reg <= prod_next;
            end
            // the new velocity replaces v for the position update
            if (ctrl.word.alu == iaas_pkg::ALU_VEL)
            begin
                v_reg <= acc_next[iaas_pkg::VAL_W-1:0];
            end
        end
    end

    // per-axis state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                vel_mem[i] <= '0;
                pos_mem[i] <= '0;
            end
        end
        else if (wr_state)
        begin
            vel_mem[idx] <= v_reg;
            pos_mem[idx] <= acc_next[iaas_pkg::VAL_W-1:0];
        end
    end

    assign status.bad_axis = bad_axis;
    assign status.axis     = axis_reg;
    assign status.position = acc_next[iaas_pkg::VAL_W-1:0];

endmodule

// ===== rtl/impedance_admittance_axis_step_unit.sv =====
// ============================================================================
// impedance_admittance_axis_step_unit
// Admittance (mass-spring-damper) step for one axis per force sample, run by
// a short microprogram over one shared multiplier.
// ============================================================================
//
//  channel   dir   handshake          word
//  -------   ---   ---------          ----
//  sample    in    valid / ready      axis, force_req
//  result    out   valid / ready      axis_out, position
//  apb       in    psel & penable     gain, time step and limit registers
//
//  An axis in range runs nine microprogram steps from acceptance to the next
//  acceptance, set by the single shared multiplier whose five products run in
//  series, each followed by an accumulator step.
//  An axis out of range jumps straight to the final step.
//  Reset sets the configuration registers to their defaults and every axis state to zero.
//  The result word sits in an output register; a stalled result holds the
//  final step only when a new word is ready and the old one is not taken.
//
module impedance_admittance_axis_step_unit
#(
    parameter int AXIS_COUNT = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iaas_pkg::ADDR_W-1:0]   paddr,
    input  logic [iaas_pkg::DATA_W-1:0]   pwdata,
    output logic [iaas_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    iaas_sample_if.sink                   sample,
    iaas_result_if.source                 result
);

    iaas_pkg::cfg_t                  cfg;
    iaas_pkg::dp_ctrl_t              dp_ctrl;
    iaas_pkg::dp_status_t            status;
    iaas_pkg::ctrl_word_t            uc;

    logic                            busy_reg;
    logic                            busy_next;
    logic [iaas_pkg::STEP_W-1:0]     step_reg;
    logic [iaas_pkg::STEP_W-1:0]     step_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [iaas_pkg::AXIS_W-1:0]     out_axis_reg;
    logic [iaas_pkg::VAL_W-1:0]      out_pos_reg;

    logic                            accept;
    logic                            hold;
    logic                            advance;
    logic                            commit;

    iaas_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iaas_datapath #(.AXIS_COUNT(AXIS_COUNT)) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dp_ctrl),
        .axis_in  (sample.axis),
        .force_in (sample.force_req),
        .cfg      (cfg),
        .status   (status)
    );

    // control store lookup and handshake
    assign uc           = iaas_pkg::ucode(step_reg);
    assign sample.ready = ~busy_reg;
    assign accept       = sample.valid & ~busy_reg;
    assign hold         = busy_reg & uc.last & out_valid_reg & ~result.ready;
    assign advance      = busy_reg & ~hold;
    assign commit       = advance & uc.last;

    assign dp_ctrl.load    = accept;
    assign dp_ctrl.step_en = advance;
    assign dp_ctrl.word    = uc;

    // step counter with conditional jump
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end
        else if (advance)
        begin
            if (uc.jmp_bad && status.bad_axis)
            begin
                step_next = uc.target;
            end
            else
            begin
                step_next = iaas_pkg::STEP_W'(step_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // output register
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_axis_reg <= status.axis;
            out_pos_reg  <= status.position;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.axis_out = out_axis_reg;
    assign result.position = $signed(out_pos_reg);

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> busy_reg)
        else $error("sequencer not started after an accepted word");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> int'(step_reg) < iaas_pkg::STEP_COUNT)
        else $error("step counter beyond the control store");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(busy_reg))
        else $error("result raised without a running item");

    a_bad_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && int'(result.axis_out) >= AXIS_COUNT |-> result.position == 16'sd0)
        else $error("axis out of range gave a non-zero position");

endmodule
